@@ rtl/core/pedr_pkg.sv @@
// pedr_pkg: shared widths, codes and controller/datapath structs
// for the pairwise euclidean distance row block
// no dependencies
`default_nettype none

package pedr_pkg;

  // payload field widths
  localparam int OP_W       = 1;
  localparam int PIDX_W     = 6;
  localparam int CIDX_W     = 4;
  localparam int COORD_W    = 16;
  localparam int DIST_W     = 18;
  localparam int NUMP_W     = 7;
  localparam int DIM_W      = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 7;

  // squared sum is unsigned Q20.16 with headroom for the coordinate count
  localparam int SUM_W      = 2 * DIST_W;
  localparam int REM_W      = DIST_W + 3;
  localparam int SQ_STEPS   = DIST_W;
  localparam int STEP_W     = 5;

  // rows and coordinates reachable through the payload fields
  localparam int ROW_CAP    = 64;
  localparam int COORD_CAP  = 16;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_MAX_DIM    = 16;

  // input op codes
  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_ROW  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PT_COUNT    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_COORD_COUNT = 1'b1;

  typedef struct packed {
    logic              wr_en;
    logic [PIDX_W-1:0] wr_point;
    logic [CIDX_W-1:0] wr_coord;
    logic              rd_en;
    logic [PIDX_W-1:0] rd_row;
    logic [PIDX_W-1:0] rd_col;
    logic [CIDX_W-1:0] rd_coord;
    logic              acc_clear;
    logic              sqrt_start;
    logic              sqrt_step;
    logic              out_load;
    logic [PIDX_W-1:0] out_column;
    logic              out_err;
    logic              out_last;
  } pedr_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } pedr_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/pedr_in_if.sv @@
// pedr_in_if: request channel carrying coordinate loads and row requests
// depends on pedr_pkg
`default_nettype none

interface pedr_in_if;
  import pedr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic [PIDX_W-1:0]         point_index;
  logic [CIDX_W-1:0]         coord_index;
  logic signed [COORD_W-1:0] coord_value;

  modport source (output valid, output op, output point_index, output coord_index,
                  output coord_value, input ready);
  modport sink   (input valid, input op, input point_index, input coord_index,
                  input coord_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pedr_out_if.sv @@
// pedr_out_if: result channel, one distance per column
// depends on pedr_pkg
`default_nettype none

interface pedr_out_if;
  import pedr_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIDX_W-1:0] column;
  logic [DIST_W-1:0] distance;
  logic              status;
  logic              last;

  modport source (output valid, output column, output distance, output status,
                  output last, input ready);
  modport sink   (input valid, input column, input distance, input status,
                  input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pedr_cfg_if.sv @@
// pedr_cfg_if: configuration register write channel
// depends on pedr_pkg
`default_nettype none

interface pedr_cfg_if;
  import pedr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pedr_dp.sv @@
// pedr_dp: point memory, difference/square/accumulate pipeline,
// bit-pair square root and result register; depends on pedr_pkg
`default_nettype none

module pedr_dp #(
  parameter int MAX_POINTS = pedr_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIM    = pedr_pkg::DEF_MAX_DIM
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pedr_pkg::pedr_cmd_t                cmd,
  input  logic signed [pedr_pkg::COORD_W-1:0] wr_data,
  output pedr_pkg::pedr_stat_t               stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pedr_pkg::PIDX_W-1:0]        out_column,
  output logic [pedr_pkg::DIST_W-1:0]        out_distance,
  output logic                               out_status,
  output logic                               out_last
);
  import pedr_pkg::*;

  localparam int NPT   = (MAX_POINTS < ROW_CAP) ? MAX_POINTS : ROW_CAP;
  localparam int NDIM  = (MAX_DIM < COORD_CAP) ? MAX_DIM : COORD_CAP;
  localparam int PA_W  = $clog2(NPT);
  localparam int CA_W  = (NDIM > 1) ? $clog2(NDIM) : 1;
  localparam int AW    = PA_W + CA_W;
  localparam int DEPTH = 2 ** AW;

  logic [COORD_W-1:0] mem [DEPTH];
  logic [COORD_W-1:0] rd_a;
  logic [COORD_W-1:0] rd_b;
  logic               v_rd;
  logic               v_df;
  logic               v_sq;
  logic [COORD_W-1:0] mag;
  logic [2*COORD_W-1:0] sq;
  logic [SUM_W-1:0]   acc;
  logic [SUM_W-1:0]   rad;
  logic [REM_W-1:0]   rem;
  logic [DIST_W-1:0]  root;

  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr_a;
  logic [AW-1:0]      raddr_b;
  logic signed [COORD_W:0] diff;
  logic [COORD_W:0]   diff_abs;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;
  logic               take;

  assign waddr   = {cmd.wr_point[PA_W-1:0], cmd.wr_coord[CA_W-1:0]};
  assign raddr_a = {cmd.rd_row[PA_W-1:0], cmd.rd_coord[CA_W-1:0]};
  assign raddr_b = {cmd.rd_col[PA_W-1:0], cmd.rd_coord[CA_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a <= mem[raddr_a];
      rd_b <= mem[raddr_b];
    end
  end

  // row point minus column point, then magnitude
  always_comb begin
    diff     = $signed({rd_a[COORD_W-1], rd_a}) - $signed({rd_b[COORD_W-1], rd_b});
    diff_abs = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd <= 1'b0;
      v_df <= 1'b0;
      v_sq <= 1'b0;
    end else begin
      v_rd <= cmd.rd_en;
      v_df <= v_rd;
      v_sq <= v_df;
    end
  end

  always_ff @(posedge clk) begin
    mag <= diff_abs[COORD_W-1:0];
    sq  <= mag * mag;
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (v_sq) begin
      acc <= acc + SUM_W'(sq);
    end
  end

  // floor square root, two radicand bits per step
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[SUM_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad  <= acc;
      rem  <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad  <= {rad[SUM_W-3:0], 2'b00};
      rem  <= take ? (rem_sh - trial) : rem_sh;
      root <= {root[DIST_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_column   <= cmd.out_column;
      out_distance <= cmd.out_err ? '0 : root;
      out_status   <= cmd.out_err;
      out_last     <= cmd.out_last;
    end
  end

  assign stat.pipe_busy = v_rd | v_df | v_sq;
  assign stat.out_free  = !out_valid | out_ready;

endmodule

`default_nettype wire

@@ rtl/core/pedr_ctrl.sv @@
// pedr_ctrl: configuration registers and the row sequencer that drives
// the datapath by command struct; depends on pedr_pkg
`default_nettype none

module pedr_ctrl #(
  parameter int MAX_POINTS = pedr_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIM    = pedr_pkg::DEF_MAX_DIM
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic [pedr_pkg::OP_W-1:0]            req_op,
  input  logic [pedr_pkg::PIDX_W-1:0]          req_point,
  input  logic [pedr_pkg::CIDX_W-1:0]          req_coord,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pedr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pedr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  pedr_pkg::pedr_stat_t                 stat,
  output pedr_pkg::pedr_cmd_t                  cmd
);
  import pedr_pkg::*;

  localparam int NPT  = (MAX_POINTS < ROW_CAP) ? MAX_POINTS : ROW_CAP;
  localparam int NDIM = (MAX_DIM < COORD_CAP) ? MAX_DIM : COORD_CAP;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_ERR   = 3'd5;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [PIDX_W-1:0] row;
  logic [PIDX_W-1:0] row_next;
  logic [PIDX_W-1:0] col;
  logic [PIDX_W-1:0] col_next;
  logic [CIDX_W-1:0] k;
  logic [CIDX_W-1:0] k_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [NUMP_W-1:0] pt_count;
  logic [DIM_W-1:0]  coord_count;

  logic [NUMP_W-1:0] n_eff;
  logic [DIM_W-1:0]  d_eff;
  logic              req_xfer;
  logic              col_last;
  logic              k_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_count    <= NUMP_W'(1);
      coord_count <= DIM_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_PT_COUNT:    pt_count    <= cfg_data[NUMP_W-1:0];
        REG_COORD_COUNT: coord_count <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // registers saturate into the supported range
  always_comb begin
    if (pt_count == '0) begin
      n_eff = NUMP_W'(1);
    end else if (32'(pt_count) > NPT) begin
      n_eff = NUMP_W'(NPT);
    end else begin
      n_eff = pt_count;
    end
    if (coord_count == '0) begin
      d_eff = DIM_W'(1);
    end else if (32'(coord_count) > NDIM) begin
      d_eff = DIM_W'(NDIM);
    end else begin
      d_eff = coord_count;
    end
  end

  assign req_ready = (state == S_IDLE);
  assign req_xfer  = req_valid & req_ready;
  assign col_last  = ({1'b0, col} == (n_eff - NUMP_W'(1)));
  assign k_last    = ({1'b0, k} == (d_eff - DIM_W'(1)));

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    k_next     = k;
    step_next  = step;
    cmd        = '0;
    cmd.wr_point = req_point;
    cmd.wr_coord = req_coord;
    cmd.rd_row   = row;
    cmd.rd_col   = col;
    cmd.rd_coord = k;
    cmd.out_column = col;
    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          if (req_op == OP_LOAD) begin
            cmd.wr_en = (32'(req_point) < MAX_POINTS) && (32'(req_coord) < MAX_DIM);
          end else begin
            row_next = req_point;
            if ({1'b0, req_point} >= n_eff) begin
              state_next = S_ERR;
            end else begin
              col_next      = '0;
              k_next        = '0;
              cmd.acc_clear = 1'b1;
              state_next    = S_READ;
            end
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (k_last) begin
          k_next     = '0;
          state_next = S_DRAIN;
        end else begin
          k_next = k + CIDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.sqrt_start = 1'b1;
          step_next      = '0;
          state_next     = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_next     = step + STEP_W'(1);
        if (step == STEP_W'(SQ_STEPS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = col_last;
          if (col_last) begin
            state_next = S_IDLE;
          end else begin
            col_next      = col + PIDX_W'(1);
            cmd.acc_clear = 1'b1;
            state_next    = S_READ;
          end
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_column = row;
          cmd.out_err    = 1'b1;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= '0;
      col   <= '0;
      k     <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      k     <= k_next;
      step  <= step_next;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded while output register still occupied");

  a_read_in_rows: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> ({1'b0, cmd.rd_col} < n_eff) && ({1'b0, cmd.rd_row} < n_eff))
    else $error("point read outside rows in use");

  a_sqrt_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |-> !stat.pipe_busy && !$past(cmd.rd_en))
    else $error("square root started before accumulation finished");

  a_no_req_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |=> !req_ready)
    else $error("request taken while a column is in progress");

endmodule

`default_nettype wire

@@ rtl/core/pairwise_euclidean_distance_rows.sv @@
// Pairwise euclidean distance rows: stores signed Q8.8 points and returns
// distance rows. Usage:
//   req: op load writes one coordinate (point_index, coord_index,
//        coord_value); op row asks for the distance row of point_index.
//   rsp: one result per column below the point count in ascending order,
//        the floor square root of the squared sum in unsigned Q10.8, last set on the
//        final one; a row at or above the point count gives a single result
//        with status 1, distance 0, column equal to the request's point.
//   cfg: register 0 point count, register 1 coordinates per point; always
//        ready; written by the user while no row is in progress (not enforced).
// Row flow: for points of d coordinates, each column reads d coordinate
//   pairs through the two-port point memory, drains a 3-stage subtract,
//   square and accumulate pipe, then runs the 18-step square root unit.
//   An out-of-range row skips these steps and gives its error result.
// A stalled receiver holds the sequencer at the next result; the request
//   channel is ready again once the last result sits in the output register.
// Reset sets both registers to 1 and empties the output register;
//   point memory is not cleared and must be loaded before rows are read.
`default_nettype none

module pairwise_euclidean_distance_rows #(
  parameter int MAX_POINTS = pedr_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIM    = pedr_pkg::DEF_MAX_DIM
) (
  input  logic       clk,
  input  logic       rst,
  pedr_in_if.sink    req,
  pedr_out_if.source rsp,
  pedr_cfg_if.sink   cfg
);
  import pedr_pkg::*;

  pedr_cmd_t  cmd;
  pedr_stat_t stat;

  pedr_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DIM    (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_op    (req.op),
    .req_point (req.point_index),
    .req_coord (req.coord_index),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_addr  (cfg.addr),
    .cfg_data  (cfg.data),
    .stat      (stat),
    .cmd       (cmd)
  );

  pedr_dp #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DIM    (MAX_DIM)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .wr_data      (req.coord_value),
    .stat         (stat),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_column   (rsp.column),
    .out_distance (rsp.distance),
    .out_status   (rsp.status),
    .out_last     (rsp.last)
  );

endmodule

`default_nettype wire
